### rtl/core/nllp_pkg.sv
package nllp_pkg;

   localparam int SampleBitsDefault = 24;
   localparam int StateBitsDefault = 32;
   localparam int WorkBits = 32;
   localparam int WorkFrac = 28;
   localparam int CutBits = 16;
   localparam int CutFrac = 14;
   localparam int WideBits = 64;

   localparam logic signed [WorkBits-1:0] WorkMax = {1'b0, {(WorkBits-1){1'b1}}};
   localparam logic signed [WorkBits-1:0] WorkMin = {1'b1, {(WorkBits-1){1'b0}}};

   typedef logic signed [WorkBits-1:0] work_type;
   typedef logic signed [WideBits-1:0] wide_type;

   // shared unit operations
   localparam logic [2:0] OpMul = 3'd0;
   localparam logic [2:0] OpAdd = 3'd1;
   localparam logic [2:0] OpSub = 3'd2;
   localparam logic [2:0] OpTanh = 3'd3;
   localparam logic [2:0] OpRecip = 3'd4;

   typedef struct packed {
      logic       start;
      logic [2:0] op;
      work_type   a;
      work_type   b;
   } alu_cmd_type;

   typedef struct packed {
      logic     done;
      work_type result;
   } alu_rsp_type;

   function automatic work_type sat_work(input logic signed [WideBits-1:0] v);
      if (v > wide_type'(WorkMax)) begin
         return WorkMax;
      end else if (v < wide_type'(WorkMin)) begin
         return WorkMin;
      end
      return v[WorkBits-1:0];
   endfunction

endpackage

### rtl/core/nllp_stream_if.sv
interface nllp_stream_if #(
   parameter int PayloadBits = 8
);
   logic                   valid;
   logic                   ready;
   logic [PayloadBits-1:0] payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/nllp_alu.sv
module nllp_alu
   import nllp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  alu_cmd_type cmd,
   output alu_rsp_type rsp
);

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StPoly = 2'd1;
   localparam logic [1:0] StDiv = 2'd2;
   localparam logic [1:0] StDone = 2'd3;

   localparam logic [WideBits-1:0] K945 = WideBits'(945) << WorkFrac;

   logic [1:0]          state_ff, state_in;
   logic [2:0]          pstep_ff, pstep_in;
   logic [4:0]          dcnt_ff, dcnt_in;
   logic [WideBits-1:0] num_ff, num_in;
   logic [WideBits-1:0] den_ff, den_in;
   logic [WideBits-1:0] acc_ff, acc_in;
   logic [WideBits-1:0] aa_ff, aa_in;
   logic [WorkBits-1:0] q_ff, q_in;
   work_type            res_ff, res_in;
   logic                done_ff, done_in;

   logic signed [WideBits-1:0] prod;
   logic signed [WideBits-1:0] sum;
   logic [WideBits-1:0]        rsh;
   logic [57:0]                umul;

   assign prod = wide_type'(cmd.a) * wide_type'(cmd.b);
   assign sum = (cmd.op == OpSub) ? wide_type'(cmd.a) - wide_type'(cmd.b)
                                  : wide_type'(cmd.a) + wide_type'(cmd.b);
   assign rsh = {num_ff[WideBits-2:0], 1'b0};
   assign umul = acc_ff[35:0] * aa_ff[21:0];

   always_comb begin
      state_in = state_ff;
      pstep_in = pstep_ff;
      dcnt_in = dcnt_ff;
      num_in = num_ff;
      den_in = den_ff;
      acc_in = acc_ff;
      aa_in = aa_ff;
      q_in = q_ff;
      res_in = res_ff;
      done_in = 1'b0;
      unique case (state_ff)
         StIdle: begin
            if (cmd.start) begin
               unique case (cmd.op)
                  OpMul: begin
                     res_in = sat_work(prod >>> WorkFrac);
                     state_in = StDone;
                  end
                  OpAdd, OpSub: begin
                     res_in = sat_work(sum);
                     state_in = StDone;
                  end
                  OpTanh: begin
                     acc_in = WideBits'(prod) >> WorkFrac;
                     pstep_in = 3'd0;
                     state_in = StPoly;
                  end
                  OpRecip: begin
                     num_in = WideBits'(1) << WorkFrac;
                     den_in = (WideBits'(1) << WorkFrac)
                        + WideBits'(sat_work(prod >>> WorkFrac));
                     q_in = '0;
                     dcnt_in = '0;
                     state_in = StDiv;
                  end
                  default: begin
                     state_in = StDone;
                  end
               endcase
            end
         end
         StPoly: begin
            // acc holds a; aa gets a>>14, then a*(a>>14)>>14
            pstep_in = pstep_ff + 3'd1;
            unique case (pstep_ff)
               3'd0: begin
                  aa_in = acc_ff >> 14;
               end
               3'd1: begin
                  aa_in = WideBits'(umul >> 14);
               end
               3'd2: begin
                  num_in = aa_ff + acc_ff * 105 + K945;
               end
               3'd3: begin
                  den_in = aa_ff * 15 + acc_ff * 420 + K945;
               end
               default: begin
                  q_in = '0;
                  dcnt_in = '0;
                  state_in = StDiv;
               end
            endcase
         end
         StDiv: begin
            dcnt_in = dcnt_ff + 5'd1;
            if (dcnt_ff == 5'd0) begin
               if (num_ff >= den_ff) begin
                  num_in = num_ff - den_ff;
                  q_in = 32'd1;
               end
            end else begin
               if (rsh >= den_ff) begin
                  num_in = rsh - den_ff;
                  q_in = {q_ff[WorkBits-2:0], 1'b1};
               end else begin
                  num_in = rsh;
                  q_in = {q_ff[WorkBits-2:0], 1'b0};
               end
               if (dcnt_ff == 5'(WorkFrac)) begin
                  state_in = StDone;
               end
            end
         end
         default: begin
            res_in = (state_ff == StDone && q_ff != '0 && dcnt_ff != '0) ? q_ff : res_ff;
            dcnt_in = '0;
            done_in = 1'b1;
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         done_ff <= 1'b0;
         dcnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
         dcnt_ff <= dcnt_in;
      end
      pstep_ff <= pstep_in;
      num_ff <= num_in;
      den_ff <= den_in;
      acc_ff <= acc_in;
      aa_ff <= aa_in;
      q_ff <= q_in;
      res_ff <= res_in;
   end

   assign rsp.done = done_ff;
   assign rsp.result = res_ff;

endmodule

### rtl/core/nllp_seq.sv
module nllp_seq
   import nllp_pkg::*;
#(
   parameter int SampleBits = SampleBitsDefault,
   parameter int StateBits = StateBitsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [SampleBits-1:0] sample,
   input  logic [CutBits-1:0]    coef,
   output logic                  busy,
   output logic                  finish,
   output logic [SampleBits-1:0] result,
   output alu_cmd_type           cmd,
   input  alu_rsp_type           rsp
);

   localparam int Sf = SampleBits - 1;
   localparam int Tf = StateBits - 4;

   // register file slots
   localparam int RX = 0, RIH = 1, RS0 = 2, RS1 = 3, RS2 = 4, RS3 = 5;
   localparam int RT0 = 6, RT1 = 7, RT2 = 8, RT3 = 9, RT4 = 10;
   localparam int RG0 = 11, RG1 = 12, RG2 = 13, RG3 = 14;
   localparam int RK0 = 15, RK1 = 16, RK2 = 17, RK3 = 18;
   localparam int RY3 = 19, RXX = 20, RY0 = 21, RY1 = 22, RY2 = 23;
   localparam int RF = 24, RF2 = 25, RTMP = 26, RTMP2 = 27;
   localparam int NRegs = 28;

   typedef struct packed {
      logic [2:0] op;
      logic [4:0] a;
      logic [4:0] b;
      logic [4:0] d;
   } step_type;

   function automatic step_type prog(input logic [5:0] i);
      step_type s;
      s = '{OpMul, 5'd0, 5'd0, 5'd0};
      case (i)
         6'd0:  s = '{OpTanh, 5'(RIH), 5'(RIH), 5'(RT0)};
         6'd1:  s = '{OpTanh, 5'(RS0), 5'(RS0), 5'(RT1)};
         6'd2:  s = '{OpTanh, 5'(RS1), 5'(RS1), 5'(RT2)};
         6'd3:  s = '{OpTanh, 5'(RS2), 5'(RS2), 5'(RT3)};
         6'd4:  s = '{OpTanh, 5'(RS3), 5'(RS3), 5'(RT4)};
         6'd5:  s = '{OpRecip, 5'(RF), 5'(RT1), 5'(RG0)};
         6'd6:  s = '{OpRecip, 5'(RF), 5'(RT2), 5'(RG1)};
         6'd7:  s = '{OpRecip, 5'(RF), 5'(RT3), 5'(RG2)};
         6'd8:  s = '{OpRecip, 5'(RF), 5'(RT4), 5'(RG3)};
         6'd9:  s = '{OpMul, 5'(RF), 5'(RT3), 5'(RTMP)};
         6'd10: s = '{OpMul, 5'(RTMP), 5'(RG3), 5'(RK3)};
         6'd11: s = '{OpMul, 5'(RF), 5'(RT2), 5'(RTMP)};
         6'd12: s = '{OpMul, 5'(RTMP), 5'(RG2), 5'(RTMP)};
         6'd13: s = '{OpMul, 5'(RTMP), 5'(RK3), 5'(RK2)};
         6'd14: s = '{OpMul, 5'(RF), 5'(RT1), 5'(RTMP)};
         6'd15: s = '{OpMul, 5'(RTMP), 5'(RG1), 5'(RTMP)};
         6'd16: s = '{OpMul, 5'(RTMP), 5'(RK2), 5'(RK1)};
         6'd17: s = '{OpMul, 5'(RF), 5'(RT0), 5'(RTMP)};
         6'd18: s = '{OpMul, 5'(RTMP), 5'(RG0), 5'(RTMP)};
         6'd19: s = '{OpMul, 5'(RTMP), 5'(RK1), 5'(RK0)};
         6'd20: s = '{OpMul, 5'(RG3), 5'(RS3), 5'(RY3)};
         6'd21: s = '{OpMul, 5'(RK3), 5'(RG2), 5'(RTMP)};
         6'd22: s = '{OpMul, 5'(RTMP), 5'(RS2), 5'(RTMP)};
         6'd23: s = '{OpAdd, 5'(RY3), 5'(RTMP), 5'(RY3)};
         6'd24: s = '{OpMul, 5'(RK2), 5'(RG1), 5'(RTMP)};
         6'd25: s = '{OpMul, 5'(RTMP), 5'(RS1), 5'(RTMP)};
         6'd26: s = '{OpAdd, 5'(RY3), 5'(RTMP), 5'(RY3)};
         6'd27: s = '{OpMul, 5'(RK1), 5'(RG0), 5'(RTMP)};
         6'd28: s = '{OpMul, 5'(RTMP), 5'(RS0), 5'(RTMP)};
         6'd29: s = '{OpAdd, 5'(RY3), 5'(RTMP), 5'(RY3)};
         6'd30: s = '{OpMul, 5'(RK0), 5'(RX), 5'(RTMP)};
         6'd31: s = '{OpAdd, 5'(RY3), 5'(RTMP), 5'(RY3)};
         6'd32: s = '{OpMul, 5'(RT0), 5'(RX), 5'(RXX)};
         6'd33: s = '{OpMul, 5'(RF), 5'(RXX), 5'(RTMP)};
         6'd34: s = '{OpAdd, 5'(RS0), 5'(RTMP), 5'(RTMP)};
         6'd35: s = '{OpMul, 5'(RT1), 5'(RG0), 5'(RTMP2)};
         6'd36: s = '{OpMul, 5'(RTMP2), 5'(RTMP), 5'(RY0)};
         6'd37: s = '{OpMul, 5'(RF), 5'(RY0), 5'(RTMP)};
         6'd38: s = '{OpAdd, 5'(RS1), 5'(RTMP), 5'(RTMP)};
         6'd39: s = '{OpMul, 5'(RT2), 5'(RG1), 5'(RTMP2)};
         6'd40: s = '{OpMul, 5'(RTMP2), 5'(RTMP), 5'(RY1)};
         6'd41: s = '{OpMul, 5'(RF), 5'(RY1), 5'(RTMP)};
         6'd42: s = '{OpAdd, 5'(RS2), 5'(RTMP), 5'(RTMP)};
         6'd43: s = '{OpMul, 5'(RT3), 5'(RG2), 5'(RTMP2)};
         6'd44: s = '{OpMul, 5'(RTMP2), 5'(RTMP), 5'(RY2)};
         6'd45: s = '{OpSub, 5'(RXX), 5'(RY0), 5'(RTMP)};
         6'd46: s = '{OpMul, 5'(RF2), 5'(RTMP), 5'(RTMP)};
         6'd47: s = '{OpAdd, 5'(RS0), 5'(RTMP), 5'(RS0)};
         6'd48: s = '{OpSub, 5'(RY0), 5'(RY1), 5'(RTMP)};
         6'd49: s = '{OpMul, 5'(RF2), 5'(RTMP), 5'(RTMP)};
         6'd50: s = '{OpAdd, 5'(RS1), 5'(RTMP), 5'(RS1)};
         6'd51: s = '{OpSub, 5'(RY1), 5'(RY2), 5'(RTMP)};
         6'd52: s = '{OpMul, 5'(RF2), 5'(RTMP), 5'(RTMP)};
         6'd53: s = '{OpAdd, 5'(RS2), 5'(RTMP), 5'(RS2)};
         6'd54: s = '{OpMul, 5'(RT4), 5'(RY3), 5'(RTMP)};
         6'd55: s = '{OpSub, 5'(RY2), 5'(RTMP), 5'(RTMP)};
         6'd56: s = '{OpMul, 5'(RF2), 5'(RTMP), 5'(RTMP)};
         6'd57: s = '{OpAdd, 5'(RS3), 5'(RTMP), 5'(RS3)};
         default: s = '{OpMul, 5'(RF), 5'(RF), 5'(RTMP)};
      endcase
      return s;
   endfunction

   localparam logic [5:0] LastStep = 6'd57;

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StIssue = 2'd1;
   localparam logic [1:0] StWait = 2'd2;
   localparam logic [1:0] StEnd = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [5:0]          pc_ff, pc_in;
   work_type            regs_ff [NRegs];
   logic signed [StateBits-1:0] st_ff [4];
   logic signed [SampleBits-1:0] prev_ff;
   logic [SampleBits-1:0] result_ff;
   logic                finish_ff;
   step_type            cur;

   function automatic work_type to_work(input logic signed [63:0] v, input int frac);
      if (frac >= WorkFrac) begin
         return sat_work(v >>> (frac - WorkFrac));
      end
      return sat_work(v <<< (WorkFrac - frac));
   endfunction

   function automatic logic signed [StateBits-1:0] from_work(input work_type v);
      logic signed [63:0] w;
      w = 64'(v);
      if (Tf >= WorkFrac) begin
         return StateBits'(w <<< (Tf - WorkFrac));
      end
      return StateBits'(w >>> (WorkFrac - Tf));
   endfunction

   logic signed [63:0] o_w;
   logic signed [63:0] hi_w, lo_w;
   work_type x_w, p_w;

   assign cur = prog(pc_ff);
   assign x_w = to_work(64'(signed'(sample)), Sf);
   assign p_w = to_work(64'(prev_ff), Sf);

   always_comb begin
      o_w = 64'(regs_ff[RY3]);
      if (Sf >= WorkFrac) begin
         o_w = o_w <<< (Sf - WorkFrac);
      end else begin
         o_w = o_w >>> (WorkFrac - Sf);
      end
      hi_w = (64'sd1 <<< Sf) - 64'sd1;
      lo_w = -(64'sd1 <<< Sf);
      if (o_w > hi_w) o_w = hi_w;
      if (o_w < lo_w) o_w = lo_w;
   end

   always_comb begin
      state_in = state_ff;
      pc_in = pc_ff;
      unique case (state_ff)
         StIdle: begin
            if (start) begin
               pc_in = '0;
               state_in = StIssue;
            end
         end
         StIssue: begin
            state_in = StWait;
         end
         StWait: begin
            if (rsp.done) begin
               if (pc_ff == LastStep) begin
                  state_in = StEnd;
               end else begin
                  pc_in = pc_ff + 6'd1;
                  state_in = StIssue;
               end
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         pc_ff <= '0;
         finish_ff <= 1'b0;
         prev_ff <= '0;
         for (int i = 0; i < 4; i++) begin
            st_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in;
         finish_ff <= (state_ff == StEnd);
         if (state_ff == StIdle && start) begin
            prev_ff <= signed'(sample);
         end
         if (state_ff == StEnd) begin
            st_ff[0] <= from_work(regs_ff[RS0]);
            st_ff[1] <= from_work(regs_ff[RS1]);
            st_ff[2] <= from_work(regs_ff[RS2]);
            st_ff[3] <= from_work(regs_ff[RS3]);
            result_ff <= o_w[SampleBits-1:0];
         end
      end
      if (state_ff == StIdle && start) begin
         regs_ff[RX] <= x_w;
         regs_ff[RIH] <= work_type'((64'(x_w) + 64'(p_w)) >>> 1);
         regs_ff[RS0] <= to_work(64'(st_ff[0]), Tf);
         regs_ff[RS1] <= to_work(64'(st_ff[1]), Tf);
         regs_ff[RS2] <= to_work(64'(st_ff[2]), Tf);
         regs_ff[RS3] <= to_work(64'(st_ff[3]), Tf);
         regs_ff[RF] <= work_type'({coef, {(WorkFrac-CutFrac){1'b0}}});
         regs_ff[RF2] <= work_type'({coef, {(WorkFrac-CutFrac+1){1'b0}}});
      end else if (state_ff == StWait && rsp.done) begin
         regs_ff[cur.d] <= rsp.result;
      end
   end

   assign cmd.start = (state_ff == StIssue);
   assign cmd.op = cur.op;
   assign cmd.a = regs_ff[cur.a];
   assign cmd.b = regs_ff[cur.b];
   assign busy = (state_ff != StIdle);
   assign finish = finish_ff;
   assign result = result_ff;

endmodule

### rtl/core/nonlinear_ladder_lowpass_unit.sv
// Each item runs 58 steps through the shared unit: five tanh gains, four reciprocal
// gains (each with a bit-serial divide) and 49 multiply/add steps; the result then
// passes through the finish flag and the pending flag to the output register.
// req_ready is low while an item is in work, so a new item enters only after the last.
// A finished item waits in the output register; the next may enter meanwhile.
// Reset: synchronous, active high; clears previous input and all integrators.
module nonlinear_ladder_lowpass_unit
   import nllp_pkg::*;
#(
   parameter int SAMPLE_BITS = SampleBitsDefault,
   parameter int STATE_BITS = StateBitsDefault
) (
   input logic              clock,
   input logic              reset,
   nllp_stream_if.sink      req,
   nllp_stream_if.source    rsp
);

   alu_cmd_type            cmd;
   alu_rsp_type            ars;
   logic                   busy, finish, start;
   logic [SAMPLE_BITS-1:0] result;
   logic                   last_ff;
   logic                   pend_ff;
   logic                   ovalid_ff;
   logic [SAMPLE_BITS-1:0] osample_ff;
   logic                   oend_ff;

   assign req.ready = !busy && !pend_ff && !finish;
   assign start = req.valid && req.ready;

   nllp_alu u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .rsp   (ars)
   );

   nllp_seq #(
      .SampleBits (SAMPLE_BITS),
      .StateBits  (STATE_BITS)
   ) u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .sample (req.payload[SAMPLE_BITS-1:0]),
      .coef   (req.payload[SAMPLE_BITS +: CutBits]),
      .busy   (busy),
      .finish (finish),
      .result (result),
      .cmd    (cmd),
      .rsp    (ars)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         if (pend_ff && (!ovalid_ff || rsp.ready)) begin
            pend_ff <= 1'b0;
            ovalid_ff <= 1'b1;
         end else begin
            if (rsp.valid && rsp.ready) begin
               ovalid_ff <= 1'b0;
            end
            if (finish) begin
               pend_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         last_ff <= req.payload[SAMPLE_BITS+CutBits];
      end
      if (pend_ff && (!ovalid_ff || rsp.ready)) begin
         osample_ff <= result;
         oend_ff <= last_ff;
      end
   end

   assign rsp.valid = ovalid_ff;
   assign rsp.payload = {oend_ff, osample_ff};

endmodule

### tb/tb_nonlinear_ladder_lowpass_unit.sv
module tb_nonlinear_ladder_lowpass_unit
   import nllp_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SampleBits = SampleBitsDefault;
   localparam int StateBits = StateBitsDefault;
   localparam int ReqBits = SampleBits + CutBits + 1;
   localparam int RspBits = SampleBits + 1;
   localparam int RandomItems = 1925;
   localparam int QuietItems = 150;
   localparam int DrainCycles = 1200;

   typedef struct packed {
      logic                         last_of_block;
      logic [CutBits-1:0]           cutoff_coef;
      logic signed [SampleBits-1:0] in_sample;
   } req_item_type;

   typedef struct packed {
      logic                         block_end;
      logic signed [SampleBits-1:0] out_sample;
   } rsp_item_type;

   typedef struct {
      logic signed [SampleBits-1:0] in_sample;
      logic [CutBits-1:0]           cutoff_coef;
      logic                         last_of_block;
      bit                           typed;
      logic signed [SampleBits-1:0] out_sample;
   } vector_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   errors = 0;
   bit   quiet = 1'b0;

   nllp_stream_if #(.PayloadBits(ReqBits)) req ();
   nllp_stream_if #(.PayloadBits(RspBits)) rsp ();

   nonlinear_ladder_lowpass_unit #(
      .SAMPLE_BITS(SampleBits),
      .STATE_BITS(StateBits)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // filter state of the predictor
   longint prev_in;
   longint integ [4];
   rsp_item_type pending_outputs [$];

   function automatic longint clamp_work(longint v);
      if (v > longint'(WorkMax)) return longint'(WorkMax);
      if (v < longint'(WorkMin)) return longint'(WorkMin);
      return v;
   endfunction

   function automatic longint mul_work(longint a, longint b);
      return clamp_work((a * b) >>> WorkFrac);
   endfunction

   function automatic longint frac_divide(longint unsigned num, longint unsigned den);
      longint unsigned q;
      longint unsigned r;
      q = 0;
      r = num;
      if (r >= den) begin
         q = 1;
         r -= den;
      end
      for (int i = 0; i < WorkFrac; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r -= den;
            q |= 1;
         end
      end
      return longint'(q);
   endfunction

   function automatic longint tanh_gain(longint x);
      longint unsigned a;
      longint unsigned a2;
      longint unsigned k;
      a = longint'(x * x) >> WorkFrac;
      a2 = (a * (a >> 14)) >> 14;
      k = longint'(945) << WorkFrac;
      return frac_divide(a2 + 105 * a + k, 15 * a2 + 420 * a + k);
   endfunction

   function automatic longint recip_gain(longint f, longint t);
      longint unsigned one;
      one = longint'(1) << WorkFrac;
      return frac_divide(one, one + longint'(mul_work(f, t)));
   endfunction

   function automatic rsp_item_type filter_sample(req_item_type it);
      longint f, f2x, x, ih, o;
      longint s [4];
      longint t [5];
      longint g [4];
      longint k [4];
      longint y [4];
      longint xx;
      rsp_item_type r;
      f = longint'(it.cutoff_coef) << (WorkFrac - CutFrac);
      f2x = f * 2;
      x = clamp_work(longint'(it.in_sample) << (WorkFrac - (SampleBits - 1)));
      ih = (x + clamp_work(prev_in << (WorkFrac - (SampleBits - 1)))) >>> 1;
      for (int i = 0; i < 4; i++) s[i] = clamp_work(integ[i] >>> (StateBits - 4 - WorkFrac));
      prev_in = longint'(it.in_sample);
      t[0] = tanh_gain(ih);
      for (int i = 0; i < 4; i++) t[i+1] = tanh_gain(s[i]);
      for (int i = 0; i < 4; i++) g[i] = recip_gain(f, t[i+1]);
      k[3] = mul_work(mul_work(f, t[3]), g[3]);
      k[2] = mul_work(mul_work(mul_work(f, t[2]), g[2]), k[3]);
      k[1] = mul_work(mul_work(mul_work(f, t[1]), g[1]), k[2]);
      k[0] = mul_work(mul_work(mul_work(f, t[0]), g[0]), k[1]);
      y[3] = mul_work(g[3], s[3]);
      y[3] = clamp_work(y[3] + mul_work(mul_work(k[3], g[2]), s[2]));
      y[3] = clamp_work(y[3] + mul_work(mul_work(k[2], g[1]), s[1]));
      y[3] = clamp_work(y[3] + mul_work(mul_work(k[1], g[0]), s[0]));
      y[3] = clamp_work(y[3] + mul_work(k[0], x));
      xx = mul_work(t[0], x);
      y[0] = mul_work(mul_work(t[1], g[0]), clamp_work(s[0] + mul_work(f, xx)));
      y[1] = mul_work(mul_work(t[2], g[1]), clamp_work(s[1] + mul_work(f, y[0])));
      y[2] = mul_work(mul_work(t[3], g[2]), clamp_work(s[2] + mul_work(f, y[1])));
      s[0] = clamp_work(s[0] + mul_work(f2x, clamp_work(xx - y[0])));
      s[1] = clamp_work(s[1] + mul_work(f2x, clamp_work(y[0] - y[1])));
      s[2] = clamp_work(s[2] + mul_work(f2x, clamp_work(y[1] - y[2])));
      s[3] = clamp_work(s[3] + mul_work(f2x, clamp_work(y[2] - mul_work(t[4], y[3]))));
      for (int i = 0; i < 4; i++) integ[i] = s[i] << (StateBits - 4 - WorkFrac);
      o = y[3] >>> (WorkFrac - (SampleBits - 1));
      if (o > (longint'(1) << (SampleBits - 1)) - 1) o = (longint'(1) << (SampleBits - 1)) - 1;
      if (o < -(longint'(1) << (SampleBits - 1))) o = -(longint'(1) << (SampleBits - 1));
      r.out_sample = o[SampleBits-1:0];
      r.block_end = it.last_of_block;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // result side: check and stall
   int stall_left = 0;
   int run_left = 0;
   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            got = rsp.payload;
            if (pending_outputs.size() == 0) begin
               report_mismatch("unexpected item", got.out_sample, 0);
            end else begin
               want = pending_outputs.pop_front();
               if (got.out_sample !== want.out_sample)
                  report_mismatch("out_sample", got.out_sample, want.out_sample);
               if (got.block_end !== want.block_end)
                  report_mismatch("block_end", got.block_end, want.block_end);
            end
         end
         if (quiet) begin
            rsp.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp.ready <= 1'b0;
         end else if (run_left > 0) begin
            run_left--;
            rsp.ready <= 1'b1;
         end else begin
            if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 19);
            else run_left = $urandom_range(1, 60);
            rsp.ready <= 1'b1;
         end
      end
   end

   task automatic send_item(req_item_type it, bit typed, logic signed [SampleBits-1:0] typed_out);
      rsp_item_type pred;
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 19);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.payload <= it;
      do @(posedge clock); while (!req.ready);
      pred = filter_sample(it);
      if (typed) pred.out_sample = typed_out;
      pending_outputs.push_back(pred);
   endtask

   vector_type vectors [] = '{
      '{24'sd0, 16'd0, 1'b0, 1'b1, 24'sd0},
      '{24'sh7FFFFF, 16'd0, 1'b1, 1'b1, 24'sd0},
      '{-24'sh800000, 16'd0, 1'b0, 1'b1, 24'sd0},
      '{24'sd0, 16'd0, 1'b1, 1'b1, 24'sd0},
      '{24'sh7FFFFF, 16'hFFFF, 1'b0, 1'b0, 24'sd0},
      '{24'sh7FFFFF, 16'hFFFF, 1'b0, 1'b0, 24'sd0},
      '{-24'sh800000, 16'hFFFF, 1'b1, 1'b0, 24'sd0},
      '{-24'sh800000, 16'd0, 1'b0, 1'b0, 24'sd0},
      '{24'sd1, 16'd1, 1'b0, 1'b0, 24'sd0},
      '{-24'sd1, 16'd16384, 1'b0, 1'b0, 24'sd0},
      '{24'sh400000, 16'd8192, 1'b0, 1'b0, 24'sd0},
      '{24'sh400000, 16'd8192, 1'b0, 1'b0, 24'sd0},
      '{24'sh400000, 16'd32768, 1'b1, 1'b0, 24'sd0},
      '{-24'sh400000, 16'd49152, 1'b0, 1'b0, 24'sd0},
      '{24'sh2AAAAA, 16'hAAAA, 1'b0, 1'b0, 24'sd0},
      '{24'sh555555, 16'h5555, 1'b1, 1'b0, 24'sd0},
      '{24'sh7FFFFF, 16'd0, 1'b0, 1'b0, 24'sd0},
      '{24'sd0, 16'd2000, 1'b0, 1'b0, 24'sd0},
      '{24'sd0, 16'd2000, 1'b1, 1'b0, 24'sd0}
   };

   initial begin
      req_item_type it;
      int waited;
      req.valid = 1'b0;
      req.payload = '0;
      prev_in = 0;
      for (int i = 0; i < 4; i++) integ[i] = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (vectors[i]) begin
         it.in_sample = vectors[i].in_sample;
         it.cutoff_coef = vectors[i].cutoff_coef;
         it.last_of_block = vectors[i].last_of_block;
         send_item(it, vectors[i].typed, vectors[i].out_sample);
      end
      for (int n = 0; n < RandomItems; n++) begin
         if (n >= RandomItems - QuietItems) quiet = 1'b1;
         case ($urandom_range(0, 9))
            0: it.in_sample = $urandom_range(0, 1) ? 24'sh7FFFFF : -24'sh800000;
            1, 2: it.in_sample = $signed(24'($urandom_range(0, 8191))) - 24'sd4096;
            default: it.in_sample = 24'($urandom);
         endcase
         case ($urandom_range(0, 9))
            0: it.cutoff_coef = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
            1, 2: it.cutoff_coef = 16'($urandom);
            default: it.cutoff_coef = 16'($urandom_range(1, 20000));
         endcase
         it.last_of_block = ($urandom_range(0, 7) == 0);
         send_item(it, 1'b0, '0);
      end
      req.valid <= 1'b0;
      waited = 0;
      while (pending_outputs.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (DrainCycles) @(posedge clock);
      if (pending_outputs.size() != 0) begin
         report_mismatch("items never returned", pending_outputs.size(), 0);
      end
      if (errors == 0) begin
         $display("nonlinear_ladder_lowpass_unit test passed");
      end else begin
         $display("nonlinear_ladder_lowpass_unit test failed");
      end
      $finish;
   end

   initial begin
      #80ms;
      $display("nonlinear_ladder_lowpass_unit test failed");
      $finish;
   end

endmodule
